// ===== design/zoned_color_locked_stack_defines.svh =====
// assertion macros for the zoned color stack
`ifndef ZONED_COLOR_LOCKED_STACK_DEFINES_SVH
`define ZONED_COLOR_LOCKED_STACK_DEFINES_SVH

`ifndef SYNTHESIS
`define ZCLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("zcls assertion failed");
`define ZCLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("zcls assertion failed");
`else
`define ZCLS_ASSERT(lbl, clk, rst_n, prop)
`define ZCLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/zcls_pkg.sv =====
package zcls_pkg;

    localparam int DEPTH      = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = 7;
    localparam int VALUE_W    = 32;
    localparam int TAG_W      = 2;
    localparam int WORD_W     = VALUE_W + TAG_W;
    localparam int FRAC_W     = 17;
    localparam int FSUM_W     = FRAC_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_W     = COUNT_W + FSUM_W;
    localparam int QUOT_W     = PROD_W - FRAC_SHIFT;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAC_W;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETAG = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_POPPED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_LOCKED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd4;

    localparam logic [TAG_W-1:0] TAG_WHITE = 2'd0;
    localparam logic [TAG_W-1:0] TAG_BLUE  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_RED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 1'b1;

    localparam logic [FRAC_W-1:0] WHITE_RESET = 17'd32768;
    localparam logic [FRAC_W-1:0] BLUE_RESET  = 17'd16384;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [FRAC_W-1:0]  white_frac;
        logic [FRAC_W-1:0]  blue_frac;
    } t_zone_req;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] wb;
        logic [COUNT_W-1:0] bb;
    } t_zone_rsp;

endpackage

// ===== design/zcls_if.sv =====
interface zcls_in_if;
    logic                                valid;
    logic                                ready;
    logic [zcls_pkg::FUNC_W-1:0]         func;
    logic signed [zcls_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, func, push_value, input ready);
    modport sink (input valid, func, push_value, output ready);
endinterface

interface zcls_out_if;
    logic                                valid;
    logic                                ready;
    logic [zcls_pkg::STATUS_W-1:0]       status;
    logic signed [zcls_pkg::VALUE_W-1:0] popped_value;
    logic [zcls_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, status, popped_value, entry_count, input ready);
    modport sink (input valid, status, popped_value, entry_count, output ready);
endinterface

interface zcls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [zcls_pkg::CFG_IDX_W-1:0] index;
    logic [zcls_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/zcls_ram.sv =====
module zcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/zcls_zone.sv =====
`include "zoned_color_locked_stack_defines.svh"

module zcls_zone (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zcls_pkg::t_zone_req i_req,
    output zcls_pkg::t_zone_rsp o_rsp
);
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MUL_W = 2'd1;
    localparam logic [1:0] PH_MUL_B = 2'd2;
    localparam logic [1:0] PH_FIN   = 2'd3;

    logic [1:0]                     r_phase;
    logic                           r_done;
    logic [zcls_pkg::COUNT_W-1:0]   r_cnt;
    logic [zcls_pkg::FRAC_W-1:0]    r_wf;
    logic [zcls_pkg::FSUM_W-1:0]    r_sum;
    logic [zcls_pkg::PROD_W-1:0]    r_prod;
    logic [zcls_pkg::COUNT_W-1:0]   r_wb;
    logic [zcls_pkg::COUNT_W-1:0]   r_bb;
    logic [zcls_pkg::FSUM_W-1:0]    mul_b;
    logic [zcls_pkg::PROD_W-1:0]    prod;
    logic [zcls_pkg::QUOT_W-1:0]    quot;
    logic [zcls_pkg::COUNT_W-1:0]   clamped;

    // one multiplier, shared by both bounds
    assign mul_b = (r_phase == PH_MUL_W) ? zcls_pkg::FSUM_W'(r_wf) : r_sum;
    assign prod  = zcls_pkg::PROD_W'(r_cnt) * zcls_pkg::PROD_W'(mul_b);

    assign quot    = r_prod[zcls_pkg::PROD_W-1:zcls_pkg::FRAC_SHIFT];
    assign clamped = (quot > zcls_pkg::QUOT_W'(r_cnt)) ? r_cnt
                                                        : quot[zcls_pkg::COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= PH_MUL_W;
                    end
                end
                PH_MUL_W: r_phase <= PH_MUL_B;
                PH_MUL_B: r_phase <= PH_FIN;
                PH_FIN: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_cnt <= i_req.count;
            r_wf  <= i_req.white_frac;
            r_sum <= zcls_pkg::FSUM_W'(i_req.white_frac) + zcls_pkg::FSUM_W'(i_req.blue_frac);
        end
        if (r_phase == PH_MUL_W || r_phase == PH_MUL_B) begin
            r_prod <= prod;
        end
        if (r_phase == PH_MUL_B) begin
            r_wb <= clamped;
        end
        if (r_phase == PH_FIN) begin
            r_bb <= clamped;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.wb   = r_wb;
    assign o_rsp.bb   = r_bb;

    `ZCLS_ASSERT(a_zone_order, i_clk, i_rst_n, o_rsp.done |-> o_rsp.wb <= o_rsp.bb)
    `ZCLS_ASSERT(a_zone_clamp, i_clk, i_rst_n, o_rsp.done |-> o_rsp.bb <= r_cnt)
    `ZCLS_ASSERT(a_zone_latency, i_clk, i_rst_n, (r_phase == PH_IDLE && i_req.start) |=> !r_done)
endmodule

// ===== design/zoned_color_locked_stack.sv =====
// zoned color stack: a stack of up to 64 signed 32-bit values, each tagged
// white, blue or red, held in one single-port-write ram.
// channels: i_in takes one request (func, push_value), o_out returns one
// result per request (status, popped_value, entry_count), i_cfg writes the
// white and blue zone fractions (index 0 and 1, q1.16); the user must write
// them only while idle, which the block does not enforce. every request runs
// alone; i_in.ready is high only while no request is in work. steps:
//   push      entries shift down one per cycle, then the new entry is written
//             on top; when empty only the new entry is written
//   pop       zone bounds, then a scan from the top, one ram access a cycle,
//             then the entries below the hit move up
//   locked    zone bounds, then a scan to the blue bound; none when it is zero
//   re-tag    zone bounds, then read-modify-write of every tag
//   rejected, empty or ignored requests go straight to the result
// the next request can be taken in the same cycle that o_out.valid rises.
// a finished result sits in the output register; the next request may be
// accepted while it waits, but that request holds its own result until o_out
// is free, so a stalled receiver blocks the block after one request.
// reset empties the stack and restores the fractions to one half and one quarter.
`include "zoned_color_locked_stack_defines.svh"

module zoned_color_locked_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zcls_in_if.sink     i_in,
    zcls_out_if.source  o_out,
    zcls_cfg_if.sink    i_cfg
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BOUNDS  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MOVE    = 3'd3;
    localparam logic [2:0] S_PUSH_WR = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    localparam int CW = zcls_pkg::COUNT_W;
    localparam int AW = zcls_pkg::ADDR_W;
    localparam int VW = zcls_pkg::VALUE_W;

    logic [2:0]                     r_state, n_state;
    logic [zcls_pkg::FUNC_W-1:0]    r_func, n_func;
    logic signed [VW-1:0]           r_push_value, n_push_value;
    logic [CW-1:0]                  r_count, n_count;
    logic [zcls_pkg::FRAC_W-1:0]    r_wf, r_bf;
    logic [CW-1:0]                  r_wb, n_wb;
    logic [CW-1:0]                  r_bb, n_bb;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_chk_vld, n_chk_vld;
    logic [CW-1:0]                  r_src, n_src;
    logic [CW-1:0]                  r_left, n_left;
    logic [CW-1:0]                  r_wr_idx, n_wr_idx;
    logic                           r_wr_pend, n_wr_pend;
    logic [zcls_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic signed [VW-1:0]           r_res_value, n_res_value;
    logic [CW-1:0]                  r_res_count, n_res_count;
    logic                           r_out_valid, n_out_valid;
    logic [zcls_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic signed [VW-1:0]           r_out_value, n_out_value;
    logic [CW-1:0]                  r_out_count, n_out_count;

    zcls_pkg::t_zone_req            zone_req;
    zcls_pkg::t_zone_rsp            zone_rsp;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [zcls_pkg::WORD_W-1:0]    mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic [zcls_pkg::WORD_W-1:0]    mem_rdata;
    logic [zcls_pkg::TAG_W-1:0]     rd_tag;
    logic [CW-1:0]                  chk_pos;
    logic                           eligible;
    logic                           in_acc;
    logic                           out_free;

    function automatic logic [zcls_pkg::TAG_W-1:0] zone_tag(
        input logic [CW-1:0] pos,
        input logic [CW-1:0] wb,
        input logic [CW-1:0] bb
    );
        logic [zcls_pkg::TAG_W-1:0] tag;
        if (pos < wb) begin
            tag = zcls_pkg::TAG_WHITE;
        end else if (pos < bb) begin
            tag = zcls_pkg::TAG_BLUE;
        end else begin
            tag = zcls_pkg::TAG_RED;
        end
        return tag;
    endfunction

    zcls_ram #(
        .WIDTH (zcls_pkg::WORD_W),
        .DEPTH (zcls_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    zcls_zone u_zone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (zone_req),
        .o_rsp   (zone_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.popped_value = r_out_value;
    assign o_out.entry_count  = r_out_count;

    assign zone_req.count      = r_count;
    assign zone_req.white_frac = r_wf;
    assign zone_req.blue_frac  = r_bf;
    assign zone_req.start      = in_acc && (i_in.func == zcls_pkg::FUNC_RETAG ||
                                 (i_in.func == zcls_pkg::FUNC_POP && r_count != '0));

    assign rd_tag    = mem_rdata[zcls_pkg::WORD_W-1:VW];
    assign chk_pos   = r_idx - CW'(1);
    assign eligible  = (chk_pos < r_wb) ? (rd_tag == zcls_pkg::TAG_WHITE ||
                                           rd_tag == zcls_pkg::TAG_BLUE)
                                        : (rd_tag == zcls_pkg::TAG_BLUE);
    assign mem_raddr = (r_state == S_SCAN) ? r_idx[AW-1:0] : r_src[AW-1:0];

    // memory write side
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_idx[AW-1:0];
        mem_wdata = mem_rdata;
        unique case (r_state)
            S_MOVE: begin
                mem_we = r_wr_pend;
                unique case (r_func)
                    zcls_pkg::FUNC_PUSH: mem_waddr = AW'(r_wr_idx + CW'(1));
                    zcls_pkg::FUNC_POP:  mem_waddr = AW'(r_wr_idx - CW'(1));
                    zcls_pkg::FUNC_RETAG: begin
                        mem_waddr = r_wr_idx[AW-1:0];
                        mem_wdata = {zone_tag(r_wr_idx, r_wb, r_bb), mem_rdata[VW-1:0]};
                    end
                    default: mem_we = 1'b0;
                endcase
            end
            S_PUSH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {zcls_pkg::TAG_WHITE, r_push_value};
            end
            default: mem_we = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_push_value = r_push_value;
        n_count      = r_count;
        n_wb         = r_wb;
        n_bb         = r_bb;
        n_idx        = r_idx;
        n_chk_vld    = r_chk_vld;
        n_src        = r_src;
        n_left       = r_left;
        n_wr_idx     = r_wr_idx;
        n_wr_pend    = r_wr_pend;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func       = i_in.func;
                    n_push_value = i_in.push_value;
                    n_res_status = zcls_pkg::STATUS_DONE;
                    n_res_value  = '0;
                    n_res_count  = r_count;
                    n_wr_pend    = 1'b0;
                    unique case (i_in.func)
                        zcls_pkg::FUNC_PUSH: begin
                            if (r_count >= CW'(zcls_pkg::DEPTH)) begin
                                n_res_status = zcls_pkg::STATUS_FULL;
                                n_state      = S_RESULT;
                            end else if (r_count == '0) begin
                                n_state = S_PUSH_WR;
                            end else begin
                                n_src   = r_count - CW'(1);
                                n_left  = r_count;
                                n_state = S_MOVE;
                            end
                        end
                        zcls_pkg::FUNC_POP: begin
                            if (r_count == '0) begin
                                n_res_status = zcls_pkg::STATUS_EMPTY;
                                n_state      = S_RESULT;
                            end else begin
                                n_state = S_BOUNDS;
                            end
                        end
                        zcls_pkg::FUNC_RETAG: n_state = S_BOUNDS;
                        default:              n_state = S_RESULT;
                    endcase
                end
            end
            S_BOUNDS: begin
                if (zone_rsp.done) begin
                    n_wb = zone_rsp.wb;
                    n_bb = zone_rsp.bb;
                    if (r_func == zcls_pkg::FUNC_POP) begin
                        n_idx     = '0;
                        n_chk_vld = 1'b0;
                        if (zone_rsp.bb == '0) begin
                            n_res_status = zcls_pkg::STATUS_LOCKED;
                            n_state      = S_RESULT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_src   = '0;
                        n_left  = r_count;
                        n_state = S_MOVE;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_vld && eligible) begin
                    n_res_value = mem_rdata[VW-1:0];
                    n_res_count = r_count - CW'(1);
                    n_src       = r_idx;
                    n_left      = r_count - r_idx;
                    n_state     = S_MOVE;
                end else if (r_chk_vld && r_idx == r_bb) begin
                    n_res_status = zcls_pkg::STATUS_LOCKED;
                    n_state      = S_RESULT;
                end else begin
                    n_idx     = r_idx + CW'(1);
                    n_chk_vld = 1'b1;
                end
            end
            S_MOVE: begin
                if (r_left != '0) begin
                    n_wr_idx  = r_src;
                    n_wr_pend = 1'b1;
                    n_src     = (r_func == zcls_pkg::FUNC_PUSH) ? r_src - CW'(1)
                                                                : r_src + CW'(1);
                    n_left    = r_left - CW'(1);
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        if (r_func == zcls_pkg::FUNC_PUSH) begin
                            n_state = S_PUSH_WR;
                        end else begin
                            if (r_func == zcls_pkg::FUNC_POP) begin
                                n_res_status = zcls_pkg::STATUS_POPPED;
                            end
                            n_state = S_RESULT;
                        end
                    end
                end
            end
            S_PUSH_WR: begin
                n_res_count = r_count + CW'(1);
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_count  = r_res_count;
                    n_count      = r_res_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_wf        <= zcls_pkg::WHITE_RESET;
            r_bf        <= zcls_pkg::BLUE_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
            r_chk_vld   <= n_chk_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    zcls_pkg::CFG_WHITE: r_wf <= i_cfg.data;
                    zcls_pkg::CFG_BLUE:  r_bf <= i_cfg.data;
                    default:             r_wf <= r_wf;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_push_value <= n_push_value;
        r_wb         <= n_wb;
        r_bb         <= n_bb;
        r_idx        <= n_idx;
        r_src        <= n_src;
        r_left       <= n_left;
        r_wr_idx     <= n_wr_idx;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_count  <= n_res_count;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
    end

    `ZCLS_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(zcls_pkg::DEPTH))
    `ZCLS_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) |-> !mem_we)
    `ZCLS_ASSERT(a_value_zero, i_clk, i_rst_n, (o_out.valid && o_out.status != zcls_pkg::STATUS_POPPED) |-> o_out.popped_value == '0)
    `ZCLS_ASSERT(a_count_shown, i_clk, i_rst_n, o_out.valid |-> o_out.entry_count == r_count)
endmodule

// ===== bench/zoned_color_locked_stack_tb.sv =====
`timescale 1ns / 100ps

module zoned_color_locked_stack_tb;

    localparam int CLK_HALF    = 10;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DEPTH       = zcls_pkg::DEPTH;
    localparam int VW          = zcls_pkg::VALUE_W;
    localparam int FW          = zcls_pkg::FRAC_W;
    localparam int TAIL_CYCLES = 2 * DEPTH + 20;
    localparam int PHASE_ITEMS = 80;
    localparam int PHASE_COUNT = 10;

    typedef struct packed {
        logic [zcls_pkg::STATUS_W-1:0] status;
        logic signed [VW-1:0]          popped_value;
        logic [zcls_pkg::COUNT_W-1:0]  entry_count;
    } t_stack_result;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_style;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    zcls_in_if  req_ch ();
    zcls_out_if rsp_ch ();
    zcls_cfg_if cfg_ch ();

    zoned_color_locked_stack dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // stack contents as the block should hold them, position 0 on top
    logic signed [VW-1:0]          stack_vals [DEPTH];
    logic [zcls_pkg::TAG_W-1:0]    stack_tags [DEPTH];
    int                            held_entries = 0;
    logic [FW-1:0]                 white_frac = zcls_pkg::WHITE_RESET;
    logic [FW-1:0]                 blue_frac  = zcls_pkg::BLUE_RESET;

    t_stack_result pending_results [$];
    t_stack_result due_result;
    int            err_count = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    bit            tx_gaps = 1'b0;
    t_rx_style     rx_style = RX_OPEN;
    int unsigned   rx_phase = 0;

    function automatic void zone_limits(output int wb, output int bb);
        longint unsigned n;
        longint unsigned w;
        longint unsigned b;
        n = held_entries;
        w = (n * 64'(white_frac)) >> zcls_pkg::FRAC_SHIFT;
        b = (n * (64'(white_frac) + 64'(blue_frac))) >> zcls_pkg::FRAC_SHIFT;
        if (w > n) w = n;
        if (b > n) b = n;
        wb = int'(w);
        bb = int'(b);
    endfunction

    function automatic logic signed [VW-1:0] take_entry(int pos);
        logic signed [VW-1:0] v;
        v = stack_vals[pos];
        for (int i = pos; i < held_entries - 1; i++) begin
            stack_vals[i] = stack_vals[i + 1];
            stack_tags[i] = stack_tags[i + 1];
        end
        held_entries--;
        return v;
    endfunction

    function automatic t_stack_result stack_apply(logic [zcls_pkg::FUNC_W-1:0] fn,
                                                  logic signed [VW-1:0] val);
        t_stack_result res;
        int            wb;
        int            bb;
        bit            found;
        res   = '0;
        found = 1'b0;
        case (fn)
            zcls_pkg::FUNC_PUSH: begin
                if (held_entries >= DEPTH) begin
                    res.status = zcls_pkg::STATUS_FULL;
                end else begin
                    for (int i = held_entries; i > 0; i--) begin
                        stack_vals[i] = stack_vals[i - 1];
                        stack_tags[i] = stack_tags[i - 1];
                    end
                    stack_vals[0] = val;
                    stack_tags[0] = zcls_pkg::TAG_WHITE;
                    held_entries++;
                    res.status = zcls_pkg::STATUS_DONE;
                end
            end
            zcls_pkg::FUNC_POP: begin
                if (held_entries == 0) begin
                    res.status = zcls_pkg::STATUS_EMPTY;
                end else begin
                    zone_limits(wb, bb);
                    for (int i = 0; i < wb && !found; i++) begin
                        if (stack_tags[i] == zcls_pkg::TAG_WHITE ||
                                stack_tags[i] == zcls_pkg::TAG_BLUE) begin
                            res.popped_value = take_entry(i);
                            found = 1'b1;
                        end
                    end
                    for (int i = wb; i < bb && !found; i++) begin
                        if (stack_tags[i] == zcls_pkg::TAG_BLUE) begin
                            res.popped_value = take_entry(i);
                            found = 1'b1;
                        end
                    end
                    res.status = found ? zcls_pkg::STATUS_POPPED : zcls_pkg::STATUS_LOCKED;
                end
            end
            zcls_pkg::FUNC_RETAG: begin
                zone_limits(wb, bb);
                for (int i = 0; i < held_entries; i++) begin
                    if (i < wb) stack_tags[i] = zcls_pkg::TAG_WHITE;
                    else if (i < bb) stack_tags[i] = zcls_pkg::TAG_BLUE;
                    else stack_tags[i] = zcls_pkg::TAG_RED;
                end
                res.status = zcls_pkg::STATUS_DONE;
            end
            default: begin
                res.status = zcls_pkg::STATUS_DONE;
            end
        endcase
        res.entry_count = zcls_pkg::COUNT_W'(held_entries);
        return res;
    endfunction

    task automatic send_request(input logic [zcls_pkg::FUNC_W-1:0] fn,
                                input logic signed [VW-1:0] val);
        int gap;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 8);
                repeat (gap) @(negedge i_clk);
            end
            burst_left--;
        end
        req_ch.valid      = 1'b1;
        req_ch.func       = fn;
        req_ch.push_value = val;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(stack_apply(fn, val));
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic write_register(input logic [zcls_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [FW-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == zcls_pkg::CFG_WHITE) white_frac = val;
        else blue_frac = val;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_results;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [VW-1:0] pick_value;
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed;
        logic signed [VW-1:0] corner_vals [6];
        corner_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                        32'sh5555_5555, 32'shaaaa_aaaa};
        rx_style = RX_OPEN;
        tx_gaps  = 1'b0;
        send_request(zcls_pkg::FUNC_POP, '0);
        send_request(zcls_pkg::FUNC_RETAG, '0);
        send_request(zcls_pkg::FUNC_NONE, 32'sh7fff_ffff);
        foreach (corner_vals[i]) send_request(zcls_pkg::FUNC_PUSH, corner_vals[i]);
        send_request(zcls_pkg::FUNC_POP, '0);
        // white, white, blue, red, red: three pops then locked
        send_request(zcls_pkg::FUNC_RETAG, '0);
        repeat (4) send_request(zcls_pkg::FUNC_POP, '0);
        send_request(zcls_pkg::FUNC_NONE, -32'sd1);
        wait_results();
    endtask

    task automatic test_full_stack;
        rx_style = RX_PERIODIC;
        tx_gaps  = 1'b1;
        while (held_entries < DEPTH) send_request(zcls_pkg::FUNC_PUSH, pick_value());
        send_request(zcls_pkg::FUNC_PUSH, 32'sh7fff_ffff);
        send_request(zcls_pkg::FUNC_PUSH, pick_value());
        send_request(zcls_pkg::FUNC_RETAG, '0);
        repeat (3) send_request(zcls_pkg::FUNC_POP, '0);
        send_request(zcls_pkg::FUNC_PUSH, pick_value());
        send_request(zcls_pkg::FUNC_PUSH, pick_value());
        send_request(zcls_pkg::FUNC_NONE, pick_value());
        wait_results();
    endtask

    task automatic run_mix(input int items, input int push_pct);
        int r;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) send_request(zcls_pkg::FUNC_PUSH, pick_value());
            else if (r < push_pct + 12) send_request(zcls_pkg::FUNC_RETAG, pick_value());
            else if (r < push_pct + 15) send_request(zcls_pkg::FUNC_NONE, pick_value());
            else send_request(zcls_pkg::FUNC_POP, pick_value());
            if (n == items / 2) wait_results();
        end
    endtask

    task automatic test_zone_settings;
        logic [FW-1:0] wf_list [PHASE_COUNT];
        logic [FW-1:0] bf_list [PHASE_COUNT];
        int            push_pcts [3];
        wf_list   = '{17'd65536, 17'd0, 17'd0, 17'd65536, 17'd131071,
                      17'd1, 17'd65535, zcls_pkg::WHITE_RESET, 17'd0, 17'd0};
        bf_list   = '{17'd0, 17'd65536, 17'd0, 17'd65536, 17'd131071,
                      17'd1, 17'd1, zcls_pkg::BLUE_RESET, 17'd0, 17'd0};
        push_pcts = '{60, 35, 48};
        for (int k = 0; k < PHASE_COUNT; k++) begin
            if (k >= 8) begin
                wf_list[k] = FW'($urandom_range(0, 65536));
                bf_list[k] = FW'($urandom_range(0, 65536));
            end
            wait_results();
            write_register(zcls_pkg::CFG_WHITE, wf_list[k]);
            write_register(zcls_pkg::CFG_BLUE, bf_list[k]);
            rx_style = t_rx_style'(k % 4);
            tx_gaps  = (k % 3) != 2;
            burst_left = 0;
            run_mix(PHASE_ITEMS, push_pcts[k % 3]);
        end
    endtask

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1;
        case (rx_style)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_ch.ready <= ((rx_phase % 13) >= 5);
            default:     rsp_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                err_count++;
            end else begin
                due_result = pending_results.pop_front();
                if (rsp_ch.status !== due_result.status) begin
                    $error("status expected %0d got %0d", due_result.status, rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.popped_value !== due_result.popped_value) begin
                    $error("popped_value expected %0d got %0d",
                           due_result.popped_value, rsp_ch.popped_value);
                    err_count++;
                end
                if (rsp_ch.entry_count !== due_result.entry_count) begin
                    $error("entry_count expected %0d got %0d",
                           due_result.entry_count, rsp_ch.entry_count);
                    err_count++;
                end
            end
        end
    end

    // stuck-run guard
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[zoned_color_locked_stack] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.func       = zcls_pkg::FUNC_PUSH;
        req_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = zcls_pkg::CFG_WHITE;
        cfg_ch.data       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_stack();
        test_zone_settings();

        wait_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("[zoned_color_locked_stack] OK");
        end else begin
            $display("[zoned_color_locked_stack] ERROR");
        end
        $finish;
    end

endmodule

// ===== zoned_color_locked_stack.f =====
+incdir+design
design/zcls_pkg.sv
design/zcls_if.sv
design/zcls_ram.sv
design/zcls_zone.sv
design/zoned_color_locked_stack.sv
bench/zoned_color_locked_stack_tb.sv
